// ----- hdl/rwsf_pkg.sv -----
// Shared types, constants and the base-set lookup for the repeat word score filter.
package rwsf_pkg;

    // Configuration register indexes.
    localparam logic [7:0] CFG_REPEAT_KEY    = 8'd0;
    localparam logic [7:0] CFG_REPEAT_LEN    = 8'd1;
    localparam logic [7:0] CFG_REPEAT_PERIOD = 8'd2;
    localparam logic [7:0] CFG_MIN_SIZE      = 8'd3;
    localparam logic [7:0] CFG_MIN_SCORE     = 8'd4;
    localparam logic [7:0] CFG_FILL_CHAR     = 8'd5;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int NEED_W     = 22;

    // Scoring constants.
    localparam logic [7:0]         PAD_CHAR    = 8'h2A;
    localparam logic signed [32:0] HIT_GAIN    = 33'sd100;
    localparam logic signed [32:0] MISS_LOSS   = 33'sd100;
    localparam logic [13:0]        SCORE_SCALE = 14'd10000;
    localparam logic signed [32:0] SCORE_CAP   = 33'sd2147483647;
    localparam logic [3:0]         MAX_PERIOD  = 4'd8;

    typedef logic signed [31:0] t_score;

    typedef struct packed {
        logic [7:0] base_char;
        logic       seq_last;
    } t_in;

    typedef struct packed {
        logic [23:0] region_start;
        logic [23:0] region_end;
        logic [7:0]  fill_value;
    } t_out;

    typedef struct packed {
        logic [31:0]       key;
        logic [3:0]        key_bases;
        logic [3:0]        period;
        logic [23:0]       min_size;
        logic [NEED_W-1:0] need;
        logic [7:0]        fill;
    } t_cfg;

    // Maps an IUPAC character, either case, to its 4-bit base set.
    function automatic logic [3:0] base_bits(input logic [7:0] c);
        logic [7:0] u;
        logic [3:0] b;
        u = (c >= "a" && c <= "z") ? (c - 8'd32) : c;
        case (u)
            "A": b = 4'd1;
            "C": b = 4'd2;
            "M": b = 4'd3;
            "G": b = 4'd4;
            "R": b = 4'd5;
            "S": b = 4'd6;
            "V": b = 4'd7;
            "T": b = 4'd8;
            "U": b = 4'd8;
            "W": b = 4'd9;
            "Y": b = 4'd10;
            "H": b = 4'd11;
            "K": b = 4'd12;
            "D": b = 4'd13;
            "B": b = 4'd14;
            "N": b = 4'd15;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/rwsf_cfg_regs.sv -----
// Configuration register file with range clamping and a prescaled score threshold.
module rwsf_cfg_regs #(
    parameter int MAX_KEY_BASES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rwsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rwsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rwsf_pkg::t_cfg                 o_cfg
);
    import rwsf_pkg::*;

    localparam logic [3:0] MAX_BASES = 4'(MAX_KEY_BASES);

    t_cfg       r_cfg;
    logic [3:0] w_len_raw;
    logic [3:0] w_per_raw;
    logic [3:0] w_len_clamped;
    logic [3:0] w_per_clamped;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Clamp the length and period fields into their legal ranges.
    assign w_len_raw     = i_cfg_data[3:0];
    assign w_per_raw     = i_cfg_data[3:0];
    assign w_len_clamped = (w_len_raw == 4'd0) ? 4'd1 :
                           (w_len_raw > MAX_BASES) ? MAX_BASES : w_len_raw;
    assign w_per_clamped = (w_per_raw == 4'd0) ? 4'd1 :
                           (w_per_raw > MAX_PERIOD) ? MAX_PERIOD : w_per_raw;

    // Register write on each configuration transfer; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key       <= '0;
            r_cfg.key_bases <= 4'd1;
            r_cfg.period    <= 4'd1;
            r_cfg.min_size  <= '0;
            r_cfg.need      <= '0;
            r_cfg.fill      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REPEAT_KEY:    r_cfg.key       <= i_cfg_data;
                CFG_REPEAT_LEN:    r_cfg.key_bases <= w_len_clamped;
                CFG_REPEAT_PERIOD: r_cfg.period    <= w_per_clamped;
                CFG_MIN_SIZE:      r_cfg.min_size  <= i_cfg_data[23:0];
                CFG_MIN_SCORE:     r_cfg.need      <= NEED_W'(i_cfg_data[7:0]) *
                                                      NEED_W'(SCORE_SCALE);
                CFG_FILL_CHAR:     r_cfg.fill      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/repeat_word_score_filter.sv -----
// Top level of the repeat word score filter: input register, scoring state and result register.
// A result is registered: the character that closes it passes the input register, then fills the result register.
// Throughput: one character per cycle while the result side does not stall; the scoring state updates in one loop.
// A result transfer that stalls holds the pipeline only while the result register is full.
// Reset is synchronous and active low; it clears the configuration and the sequence state,
// so the first character after reset starts a new sequence at position 0.
module repeat_word_score_filter #(
    parameter int INDEX_BITS    = 24,
    parameter int MAX_KEY_BASES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rwsf_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rwsf_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rwsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rwsf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rwsf_pkg::*;

    localparam int IB = INDEX_BITS;
    localparam int KW = 4 * MAX_KEY_BASES;
    localparam int LW = ((IB > 24) ? IB : 24) + 3;

    t_cfg w_cfg;

    // Input register and result register.
    logic    r_in_valid;
    t_in     r_in;
    logic    r_out_valid;
    t_out    r_out;
    logic    w_go;

    // Sequence state.
    logic [KW-1:0] r_word,  n_word;
    logic [IB-1:0] r_pos,   n_pos;
    logic [3:0]    r_warm,  n_warm;
    logic [2:0]    r_skip,  n_skip;
    t_score        r_run,   n_run;
    t_score        r_peak,  n_peak;
    logic [IB-1:0] r_start, n_start;
    logic [IB-1:0] r_end,   n_end;
    logic [IB-1:0] r_pad,   n_pad;

    // Datapath nets.
    logic [KW-1:0]         w_mask;
    logic [KW-1:0]         w_shifted;
    logic                  w_match;
    t_score                w_base_run;
    t_score                w_base_peak;
    logic signed [32:0]    w_sum;
    t_score                w_sum_sat;
    logic signed [32:0]    w_dec;
    logic signed [32:0]    w_drop;
    logic                  w_close;
    logic                  w_rep_close;
    logic [IB-1:0]         w_rep_pad;
    t_score                w_rep_peak;
    logic signed [LW-1:0]  w_len;
    logic                  w_len_ok;
    logic                  w_peak_ok;
    logic                  w_rep_fire;

    rwsf_cfg_regs #(
        .MAX_KEY_BASES (MAX_KEY_BASES)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // The held character is processed when the result register is free or emptying.
    assign w_go        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Nibble mask covering the configured word length.
    always_comb begin
        for (int i = 0; i < MAX_KEY_BASES; i++) begin
            w_mask[4*i +: 4] = (4'(i) < w_cfg.key_bases) ? 4'hF : 4'h0;
        end
    end

    // Shift in the new base set and test the word against the key.
    assign w_shifted = ((r_word << 4) | KW'(base_bits(r_in.base_char))) & w_mask;
    assign w_match   = (|(w_shifted & w_cfg.key[KW-1:0])) &&
                       !(|(w_shifted & ~w_cfg.key[KW-1:0] & w_mask));

    // Score on a hit, saturating at the cap; a new region starts from zero.
    assign w_base_run  = r_run[31] ? '0 : r_run;
    assign w_base_peak = r_run[31] ? '0 : r_peak;
    assign w_sum       = {w_base_run[31], w_base_run} +
                         33'($signed({1'b0, w_cfg.period})) * HIT_GAIN;
    assign w_sum_sat   = (w_sum > SCORE_CAP) ? t_score'(SCORE_CAP) : w_sum[31:0];

    // Score on a miss and the region close test.
    assign w_dec   = {r_run[31], r_run} - MISS_LOSS;
    assign w_drop  = {r_peak[31], r_peak} - w_dec;
    assign w_close = (w_dec <= 33'sd0) || (w_drop > $signed(33'(w_cfg.need)));

    // Next sequence state.
    always_comb begin
        n_word      = r_word;
        n_pos       = r_pos + IB'(1);
        n_warm      = r_warm;
        n_skip      = r_skip;
        n_run       = r_run;
        n_peak      = r_peak;
        n_start     = r_start;
        n_end       = r_end;
        n_pad       = r_pad;
        w_rep_close = 1'b0;
        if (r_in.base_char == PAD_CHAR) begin
            n_pad = r_pad + IB'(1);
        end else begin
            n_word = w_shifted;
            if (r_warm < (w_cfg.key_bases - 4'd1)) begin
                n_warm = r_warm + 4'd1;
            end else if (r_skip != 3'd0) begin
                n_skip = r_skip - 3'd1;
            end else if (w_match) begin
                if (r_run[31]) begin
                    n_pad   = '0;
                    n_start = r_pos - IB'(w_cfg.key_bases - 4'd1);
                end
                n_run = w_sum_sat;
                if (w_sum_sat >= w_base_peak) begin
                    n_peak = w_sum_sat;
                    n_end  = r_pos;
                end else begin
                    n_peak = w_base_peak;
                end
                n_skip = 3'(w_cfg.period - 4'd1);
            end else if (r_run[31]) begin
                n_pad = '0;
                n_run = -32'sd1;
            end else begin
                n_run = w_dec[31:0];
                if (w_close) begin
                    w_rep_close = 1'b1;
                    n_peak      = '0;
                    n_pad       = '0;
                    n_run       = -32'sd1;
                end
            end
        end
    end

    // Report test: a closing region uses the state before the miss, end of sequence the state after.
    assign w_rep_pad  = w_rep_close ? r_pad  : n_pad;
    assign w_rep_peak = w_rep_close ? r_peak : n_peak;
    assign w_len      = $signed(LW'(n_end) - LW'(n_start) + LW'(1) - LW'(w_rep_pad));
    assign w_len_ok   = w_len >= $signed(LW'(w_cfg.min_size));
    assign w_peak_ok  = w_rep_peak >= $signed(32'(w_cfg.need));
    assign w_rep_fire = (w_rep_close || (r_in.seq_last && !n_run[31])) && w_len_ok && w_peak_ok;

    // Input register: load whenever it is empty or its character is being processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register: filled by a reporting character, emptied by a result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= w_rep_fire;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_rep_fire) begin
            r_out.region_start <= 24'(n_start);
            r_out.region_end   <= 24'(n_end);
            r_out.fill_value   <= w_cfg.fill;
        end
    end

    // Sequence state; the last character of a sequence returns it to the reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_go && r_in.seq_last)) begin
            r_word  <= '0;
            r_pos   <= '0;
            r_warm  <= '0;
            r_skip  <= '0;
            r_run   <= -32'sd1;
            r_peak  <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_pad   <= '0;
        end else if (w_go) begin
            r_word  <= n_word;
            r_pos   <= n_pos;
            r_warm  <= n_warm;
            r_skip  <= n_skip;
            r_run   <= n_run;
            r_peak  <= n_peak;
            r_start <= n_start;
            r_end   <= n_end;
            r_pad   <= n_pad;
        end
    end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the repeat word score filter: directed table, then random sequences.
module tb;
    import rwsf_pkg::*;

    localparam int              HALF_PERIOD = 5;
    localparam int              STALL_LIMIT = 2000;
    localparam int              ITEM_TARGET = 1500;
    localparam int              CALM_FROM   = 1300;
    localparam int              DRAIN_WAIT  = 8;
    localparam logic [7:0]      CFG_UNUSED  = 8'hFF;
    localparam logic [7:0]      DIR_FILL    = "#";
    localparam logic [8*16-1:0] SET_LETTERS = "-ACMGRSVTWYHKDBN";
    localparam longint          GAIN        = 100;
    localparam longint          LOSS        = 100;
    localparam longint          SCALE       = 10000;
    localparam longint          CAP         = 64'sd2147483647;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_REGION, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_in         item;
        t_out        region;
        logic [7:0]  idx;
        logic [31:0] val;
    } t_table_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out_data;
    logic        o_cfg_ready;

    repeat_word_score_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the configuration registers, at their reset values.
    logic [31:0] key_r       = '0;
    logic [3:0]  len_r       = 4'd1;
    logic [3:0]  period_r    = 4'd1;
    logic [23:0] min_size_r  = '0;
    logic [7:0]  min_score_r = '0;
    logic [7:0]  fill_r      = '0;

    // Predictor copy of the per-sequence scoring state.
    logic [31:0] hist_word  = '0;
    logic [23:0] seq_pos    = '0;
    logic [3:0]  warm_cnt   = '0;
    logic [2:0]  skip_cnt   = '0;
    longint      run_score  = -1;
    longint      peak_score = 0;
    logic [23:0] open_pos   = '0;
    logic [23:0] stop_pos   = '0;
    logic [23:0] pad_run    = '0;

    t_out      regions_due[$];
    t_row_kind cur_kind    = ROW_PREDICT;
    t_out      cur_region  = '0;
    int        chars_taken = 0;
    int        regs_taken  = 0;
    int        idle_cycles = 0;
    int        fail_count  = 0;
    int        items_sent  = 0;
    int        gap_pct     = 5;
    int        stall_pct   = 3;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Builds the result for the open region and tells whether it is long and strong enough.
    function automatic bit region_ready(output t_out region);
        longint span;
        span = longint'(stop_pos) - longint'(open_pos) + 1 - longint'(pad_run);
        region.region_start = open_pos;
        region.region_end   = stop_pos;
        region.fill_value   = fill_r;
        return span >= longint'(min_size_r) && peak_score >= longint'(min_score_r) * SCALE;
    endfunction

    // Scores one character against the repeat word and returns 1 when a region is reported.
    function automatic bit score_char(input t_in c, output t_out region);
        int          nb;
        int          per;
        logic [31:0] mask;
        logic [23:0] here;
        logic [7:0]  upper;
        logic [3:0]  code;
        longint      need;
        bit          fired;
        nb    = (len_r == 0) ? 1 : (len_r > 8) ? 8 : int'(len_r);
        per   = (period_r == 0) ? 1 : (period_r > 8) ? 8 : int'(period_r);
        mask  = 32'hFFFF_FFFF >> (32 - 4 * nb);
        need  = longint'(min_score_r) * SCALE;
        here  = seq_pos;
        fired = 1'b0;
        region = '0;
        seq_pos = seq_pos + 24'd1;
        if (c.base_char == PAD_CHAR) begin
            pad_run = pad_run + 24'd1;
        end else begin
            // Look the character up in the letter string; its index is the base set.
            upper = (c.base_char >= "a" && c.base_char <= "z") ?
                    c.base_char - 8'd32 : c.base_char;
            code  = (upper == "U") ? 4'd8 : 4'd0;
            for (int k = 1; k < 16; k++) begin
                if (SET_LETTERS[8*(15-k) +: 8] == upper) code = k[3:0];
            end
            hist_word = ((hist_word << 4) | {28'd0, code}) & mask;
            if (warm_cnt < nb - 1) begin
                warm_cnt = warm_cnt + 4'd1;
            end else if (skip_cnt != 0) begin
                skip_cnt = skip_cnt - 3'd1;
            end else if ((hist_word & key_r) != 0 && (hist_word & ~key_r & mask) == 0) begin
                if (run_score < 0) begin
                    pad_run    = '0;
                    peak_score = 0;
                    run_score  = 0;
                    open_pos   = here - 24'(nb - 1);
                end
                run_score = run_score + per * GAIN;
                if (run_score > CAP) run_score = CAP;
                if (run_score >= peak_score) begin
                    peak_score = run_score;
                    stop_pos   = here;
                end
                skip_cnt = 3'(per - 1);
            end else if (run_score < 0) begin
                pad_run   = '0;
                run_score = -1;
            end else begin
                run_score = run_score - LOSS;
                if (run_score <= 0 || peak_score - run_score > need) begin
                    fired      = region_ready(region);
                    peak_score = 0;
                    pad_run    = '0;
                    run_score  = -1;
                end
            end
        end
        // The last character reports a region still open, then the sequence state clears.
        if (c.seq_last) begin
            if (run_score >= 0 && !fired) fired = region_ready(region);
            hist_word  = '0;
            seq_pos    = '0;
            warm_cnt   = '0;
            skip_cnt   = '0;
            run_score  = -1;
            peak_score = 0;
            open_pos   = '0;
            stop_pos   = '0;
            pad_run    = '0;
        end
        return fired;
    endfunction

    // Checks result transfers, tracks register writes and predicts every accepted character.
    always @(posedge i_clk) begin
        t_out predicted;
        t_out want;
        bit   fired;
        bit   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (regions_due.size() == 0) begin
                    $error("unexpected region: start %0d, end %0d, fill %0d",
                           o_out_data.region_start, o_out_data.region_end,
                           o_out_data.fill_value);
                    fail_count++;
                end else begin
                    want = regions_due.pop_front();
                    if (o_out_data.region_start !== want.region_start) begin
                        $error("region_start: expected %0d, actual %0d",
                               want.region_start, o_out_data.region_start);
                        fail_count++;
                    end
                    if (o_out_data.region_end !== want.region_end) begin
                        $error("region_end: expected %0d, actual %0d",
                               want.region_end, o_out_data.region_end);
                        fail_count++;
                    end
                    if (o_out_data.fill_value !== want.fill_value) begin
                        $error("fill_value: expected %0d, actual %0d",
                               want.fill_value, o_out_data.fill_value);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                regs_taken <= regs_taken + 1;
                case (i_cfg_index)
                    CFG_REPEAT_KEY:    key_r       = i_cfg_data;
                    CFG_REPEAT_LEN:    len_r       = i_cfg_data[3:0];
                    CFG_REPEAT_PERIOD: period_r    = i_cfg_data[3:0];
                    CFG_MIN_SIZE:      min_size_r  = i_cfg_data[23:0];
                    CFG_MIN_SCORE:     min_score_r = i_cfg_data[7:0];
                    CFG_FILL_CHAR:     fill_r      = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                chars_taken <= chars_taken + 1;
                fired = score_char(i_in_data, predicted);
                if (cur_kind == ROW_REGION) begin
                    regions_due.push_back(cur_region);
                end else if (cur_kind == ROW_PREDICT && fired) begin
                    regions_due.push_back(predicted);
                end
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    // Ends the run when no transfer of any kind has happened for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // Result side stalls in random bursts.
    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offers one character, waits for its transfer and may then hold input idle for a random gap.
    task automatic send_char(input t_in c);
        int seen;
        seen = chars_taken;
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(negedge i_clk); while (chars_taken == seen);
        items_sent++;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    // Holds a register write until its transfer; the caller lowers valid after the batch.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        int seen;
        seen = regs_taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (regs_taken == seen);
    endtask

    // Stops input and waits until every predicted region has arrived and the pipeline is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (regions_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic t_table_row char_row(input t_row_kind kind, input logic [7:0] ch,
                                            input logic last, input logic [23:0] first_pos,
                                            input logic [23:0] last_pos);
        t_table_row row;
        row = '0;
        row.kind                = kind;
        row.item.base_char      = ch;
        row.item.seq_last       = last;
        row.region.region_start = first_pos;
        row.region.region_end   = last_pos;
        row.region.fill_value   = DIR_FILL;
        return row;
    endfunction

    function automatic t_table_row reg_row(input logic [7:0] idx, input logic [31:0] val);
        t_table_row row;
        row = '0;
        row.kind = ROW_CONFIG;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    initial begin
        t_table_row  rows[$];
        bit          cfg_open;
        bit          calm;
        logic [31:0] motif;
        logic [31:0] key;
        logic [3:0]  len_reg;
        logic [3:0]  per_reg;
        logic [23:0] min_size;
        logic [7:0]  min_score;
        logic [3:0]  sub;
        logic [7:0]  letter;
        t_in         c;
        int          eff_len;
        int          p;
        int          n;
        int          k;
        int          noise;
        int          pick;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset key nothing can match.
        rows.push_back(char_row(ROW_SILENT, "A", 1'b1, 0, 0));
        // Single-base key A: regions open on A and close on the first miss after the peak.
        rows.push_back(reg_row(CFG_REPEAT_KEY, 32'h1));
        rows.push_back(reg_row(CFG_REPEAT_LEN, 32'd1));
        rows.push_back(reg_row(CFG_REPEAT_PERIOD, 32'd1));
        rows.push_back(reg_row(CFG_MIN_SIZE, 32'd0));
        rows.push_back(reg_row(CFG_MIN_SCORE, 32'd0));
        rows.push_back(reg_row(CFG_FILL_CHAR, {24'd0, DIR_FILL}));
        rows.push_back(char_row(ROW_SILENT, "A", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, "a", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, PAD_CHAR, 1'b0, 0, 0));
        rows.push_back(char_row(ROW_REGION, "C", 1'b0, 0, 1));
        // A miss with no region open clears the pad count; pads before a region are dropped.
        rows.push_back(char_row(ROW_SILENT, "G", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, PAD_CHAR, 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, "A", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_REGION, "N", 1'b0, 6, 6));
        // Trailing pads make the length negative, so the signed compare rejects it.
        rows.push_back(char_row(ROW_SILENT, "A", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, PAD_CHAR, 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, PAD_CHAR, 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, "T", 1'b0, 0, 0));
        // End of sequence reports the open region, and the next sequence starts at 0.
        rows.push_back(char_row(ROW_REGION, "A", 1'b1, 12, 12));
        rows.push_back(char_row(ROW_SILENT, 8'hFF, 1'b0, 0, 0));
        rows.push_back(char_row(ROW_SILENT, 8'h00, 1'b0, 0, 0));
        rows.push_back(char_row(ROW_REGION, "A", 1'b1, 2, 2));
        // Two-base word with period two, warmup and skipping; an unknown index is ignored.
        rows.push_back(reg_row(CFG_UNUSED, 32'hFFFF_FFFF));
        rows.push_back(reg_row(CFG_REPEAT_KEY, 32'h12));
        rows.push_back(reg_row(CFG_REPEAT_LEN, 32'd2));
        rows.push_back(reg_row(CFG_REPEAT_PERIOD, 32'd2));
        rows.push_back(reg_row(CFG_MIN_SIZE, 32'd3));
        rows.push_back(char_row(ROW_PREDICT, "A", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, "C", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, "A", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, "C", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, "g", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, "T", 1'b1, 0, 0));
        // Length zero acts as one and period fifteen as eight; the pending skip is dropped.
        rows.push_back(reg_row(CFG_REPEAT_KEY, 32'h8));
        rows.push_back(reg_row(CFG_REPEAT_LEN, 32'd0));
        rows.push_back(reg_row(CFG_REPEAT_PERIOD, 32'd15));
        rows.push_back(reg_row(CFG_MIN_SIZE, 32'd0));
        rows.push_back(char_row(ROW_PREDICT, "T", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, "t", 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, PAD_CHAR, 1'b0, 0, 0));
        rows.push_back(char_row(ROW_PREDICT, "A", 1'b1, 0, 0));

        // Walk the directed table; register writes happen only once the block is idle.
        cfg_open = 1'b0;
        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CONFIG) begin
                if (!cfg_open) settle();
                write_reg(rows[r].idx, rows[r].val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) i_cfg_valid <= 1'b0;
                cfg_open   = 1'b0;
                cur_kind   = rows[r].kind;
                cur_region = rows[r].region;
                send_char(rows[r].item);
            end
        end
        cur_kind = ROW_PREDICT;

        // Random phases: a new setting, then sequences that mostly follow its repeat word.
        while (items_sent < ITEM_TARGET) begin
            settle();
            eff_len = $urandom_range(1, 8);
            len_reg = 4'(eff_len);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                len_reg = 4'd0;
                eff_len = 1;
            end else if (pick == 1) begin
                len_reg = 4'($urandom_range(9, 15));
                eff_len = 8;
            end
            p = $urandom_range(1, eff_len);
            for (int j = 0; j < 8; j++) motif[4*j +: 4] = 4'($urandom_range(1, 15));
            key = '0;
            for (int j = 0; j < eff_len; j++) key = (key << 4) | {28'd0, motif[4*(j%p) +: 4]};
            if (eff_len < 8 && $urandom_range(0, 3) == 0) key = key | ($urandom() << (4 * eff_len));
            pick = $urandom_range(0, 19);
            if (pick < 2) key = $urandom();
            else if (pick == 2) key = '0;
            else if (pick == 3) key = '1;
            per_reg = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'(p);
            pick = $urandom_range(0, 9);
            if (pick < 6) min_size = 24'($urandom_range(0, 4));
            else if (pick < 8) min_size = 24'($urandom_range(5, 30));
            else if (pick == 8) min_size = 24'hFF_FFFF;
            else min_size = 24'($urandom());
            pick = $urandom_range(0, 9);
            if (pick < 7) min_score = 8'd0;
            else if (pick == 7) min_score = 8'd1;
            else if (pick == 8) min_score = 8'd255;
            else min_score = 8'($urandom_range(0, 255));
            write_reg(CFG_REPEAT_KEY, key);
            write_reg(CFG_REPEAT_LEN, {28'($urandom()), len_reg});
            write_reg(CFG_REPEAT_PERIOD, {28'($urandom()), per_reg});
            write_reg(CFG_MIN_SIZE, {8'($urandom()), min_size});
            write_reg(CFG_MIN_SCORE, {24'($urandom()), min_score});
            write_reg(CFG_FILL_CHAR, $urandom());
            if ($urandom_range(0, 9) == 0) write_reg(8'($urandom_range(6, 255)), $urandom());
            i_cfg_valid <= 1'b0;

            // Idling varies per phase; the closing stretch of the run has none.
            calm      = items_sent >= CALM_FROM;
            pick      = $urandom_range(0, 2);
            gap_pct   = calm ? 0 : (pick == 0) ? 0 : (pick == 1) ? 5 : 15;
            pick      = $urandom_range(0, 2);
            stall_pct = calm ? 0 : (pick == 0) ? 0 : (pick == 1) ? 3 : 10;

            repeat ($urandom_range(1, 5)) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
                k = $urandom_range(0, p - 1);
                noise = 0;
                for (int i = 0; i < n; i++) begin
                    // Bursts of noise break the repeat and close regions.
                    if (noise == 0 && $urandom_range(0, 19) == 0) noise = $urandom_range(1, 8);
                    pick = $urandom_range(0, 99);
                    if (noise > 0) begin
                        c.base_char = 8'($urandom_range(0, 255));
                        noise--;
                    end else if (pick < 8) begin
                        c.base_char = PAD_CHAR;
                    end else if (pick < 13) begin
                        c.base_char = 8'($urandom_range(0, 255));
                    end else begin
                        // A letter whose base set lies within the motif base, either case.
                        sub = motif[4*k +: 4] & 4'($urandom_range(1, 15));
                        if (sub == 0) sub = motif[4*k +: 4];
                        letter = SET_LETTERS[8*(15-sub) +: 8];
                        if (sub == 4'd8 && $urandom_range(0, 1) == 1) letter = "U";
                        if ($urandom_range(0, 3) == 0) letter = letter | 8'h20;
                        c.base_char = letter;
                        k = (k + 1) % p;
                    end
                    c.seq_last = (i == n - 1);
                    send_char(c);
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
